// ===== rtl/eht_pkg.sv =====
// Shared constants, types and state codes of the extendible hash table.
`timescale 1ns / 1ps
`default_nettype none
package eht_pkg;
    localparam int MAX_DEPTH = 10;
    localparam int SLOTS     = 8;
    localparam int KEY_BITS  = 32;
    localparam int DIR_W     = MAX_DEPTH;
    localparam int DIR_ENTRIES = 1 << MAX_DEPTH;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int DEP_W     = 4;
    localparam int USED_W    = DIR_W + 1;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_SEARCH = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] CFG_INIT_DEPTH = 2'd0;
    localparam logic [1:0] CFG_CAPACITY   = 2'd1;

    typedef struct packed {
        logic [DEP_W-1:0] ld;
        logic [CNT_W-1:0] fill;
    } t_meta;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DIR, S_META, S_DECIDE, S_SRD, S_SCMP, S_RM_RD, S_RM_WR,
        S_DBL_RD, S_DBL_WR, S_SPL, S_WLK_RD, S_WLK_WR, S_RD_RD, S_RD_WR,
        S_M1, S_M2, S_DONE
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/extendible_hash_table.sv =====
// Extendible hash table: insert, search and remove of 32-bit keys.
// Input channel: i_valid / o_stall with i_func and i_key; one item at a time.
// Output channel: o_valid / i_stall with o_status and o_bucket_id, one result
// per item, held in an output register so the next item may be taken while
// a result waits.
// Search and remove scan the bucket's slots in turn; a remove then shifts the
// later keys down by one slot. Each split first copies the directory into its
// upper half when the directory must double, then walks the whole directory,
// moves the bucket's keys and writes both metadata entries; the directory,
// bucket metadata and key memories each have one read and one write port.
// After reset, and after a write of the initial depth or of the capacity, a
// clearing pass over every directory entry rebuilds directory and bucket
// metadata; o_stall is high meanwhile.
// A stalled result holds its value; the block finishes the next item and
// then waits until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module extendible_hash_table import eht_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [1:0]          i_func,
    input  wire logic signed [31:0]  i_key,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [1:0]               o_status,
    output logic [9:0]               o_bucket_id,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [3:0]          i_cfg_data
);
    logic [KEY_BITS-1:0] key_mem [DIR_ENTRIES*SLOTS];
    logic [DIR_W-1:0]    dir_mem [DIR_ENTRIES];
    t_meta               meta_mem [DIR_ENTRIES];

    t_state              r_state, n_state;
    logic [3:0]          r_init_depth, r_cap_reg;
    logic [DEP_W-1:0]    r_gd, n_gd;
    logic [USED_W-1:0]   r_used, n_used;
    logic [DIR_W-1:0]    r_i, n_i;
    logic [1:0]          r_func, n_func;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [DIR_W-1:0]    r_b, n_b, r_nb, n_nb;
    logic [DEP_W-1:0]    r_ld, n_ld;
    logic [CNT_W-1:0]    r_fill, n_fill, r_s, n_s, r_keep, n_keep, r_cnt, n_cnt;
    logic [1:0]          r_status, n_status;
    logic [DIR_W-1:0]    r_id, n_id;
    logic                r_ovalid, n_ovalid;
    logic [1:0]          r_ostat, n_ostat;
    logic [DIR_W-1:0]    r_oid, n_oid;

    logic                dir_we, meta_we, key_we;
    logic [DIR_W-1:0]    dir_wa, dir_wd, dir_ra, meta_wa, meta_ra;
    t_meta               meta_wd;
    logic [DIR_W+SLOT_W-1:0] key_wa, key_ra;
    logic [KEY_BITS-1:0] key_wd;
    logic [DIR_W-1:0]    dir_q;
    t_meta               meta_q;
    logic [KEY_BITS-1:0] key_q;

    logic [DEP_W-1:0]    eff_depth;
    logic [CNT_W-1:0]    eff_cap;
    logic [DIR_W-1:0]    gd_mask, dir_n, dir_last;

    always_comb begin
        eff_depth = (r_init_depth > 4'(MAX_DEPTH)) ? DEP_W'(MAX_DEPTH) : r_init_depth;
        if (r_cap_reg == 4'd0) eff_cap = CNT_W'(1);
        else if (r_cap_reg > 4'(SLOTS)) eff_cap = CNT_W'(SLOTS);
        else eff_cap = CNT_W'(r_cap_reg);
        dir_n    = DIR_W'((USED_W'(1) << r_gd));
        gd_mask  = DIR_W'((USED_W'(1) << r_gd) - USED_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (dir_we) dir_mem[dir_wa] <= dir_wd;
        dir_q <= dir_mem[dir_ra];
        if (meta_we) meta_mem[meta_wa] <= meta_wd;
        meta_q <= meta_mem[meta_ra];
        if (key_we) key_mem[key_wa] <= key_wd;
        key_q <= key_mem[key_ra];
    end

    always_comb begin
        n_state = r_state; n_gd = r_gd; n_used = r_used; n_i = r_i;
        n_func = r_func; n_key = r_key; n_b = r_b; n_nb = r_nb; n_ld = r_ld;
        n_fill = r_fill; n_s = r_s; n_keep = r_keep; n_cnt = r_cnt;
        n_status = r_status; n_id = r_id;
        n_ovalid = r_ovalid && i_stall; n_ostat = r_ostat; n_oid = r_oid;
        dir_we = 1'b0; dir_wa = r_i; dir_wd = r_i; dir_ra = r_i;
        meta_we = 1'b0; meta_wa = r_b; meta_wd = '{ld: r_ld, fill: r_fill}; meta_ra = r_b;
        key_we = 1'b0; key_wa = {r_b, r_fill[SLOT_W-1:0]}; key_wd = r_key;
        key_ra = {r_b, r_s[SLOT_W-1:0]};
        dir_last = (r_gd == DEP_W'(MAX_DEPTH)) ? DIR_W'(DIR_ENTRIES - 1) : gd_mask;
        unique case (r_state)
            S_CLR: begin
                dir_we = 1'b1; dir_wa = r_i; dir_wd = r_i;
                meta_we = 1'b1; meta_wa = r_i; meta_wd = '{ld: eff_depth, fill: '0};
                n_i = r_i + DIR_W'(1);
                if (r_i == DIR_W'(DIR_ENTRIES - 1)) begin
                    n_gd = eff_depth;
                    n_used = USED_W'(1) << eff_depth;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_func = i_func; n_key = KEY_BITS'(i_key);
                    n_status = ST_OK; n_id = '0;
                    n_state = (i_func == FUNC_UNUSED) ? S_DONE : S_DIR;
                end
            end
            S_DIR: begin
                dir_ra = r_key[DIR_W-1:0] & gd_mask;
                n_state = S_META;
            end
            S_META: begin
                n_b = dir_q; meta_ra = dir_q;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_ld = meta_q.ld; n_fill = meta_q.fill; n_s = '0;
                if (r_func != FUNC_INSERT) begin
                    if (meta_q.fill == '0) begin
                        n_status = ST_NOTFOUND; n_state = S_DONE;
                    end else n_state = S_SRD;
                end else if (meta_q.fill < eff_cap) begin
                    key_we = 1'b1; key_wa = {r_b, meta_q.fill[SLOT_W-1:0]};
                    meta_we = 1'b1;
                    meta_wd = '{ld: meta_q.ld, fill: meta_q.fill + CNT_W'(1)};
                    n_state = S_DONE;
                end else if (meta_q.ld >= r_gd) begin
                    if (r_gd >= DEP_W'(MAX_DEPTH)) begin
                        n_status = ST_FULL; n_state = S_DONE;
                    end else begin
                        n_i = '0; n_state = S_DBL_RD;
                    end
                end else n_state = S_SPL;
            end
            S_SRD: n_state = S_SCMP;
            S_SCMP: begin
                if (key_q == r_key) begin
                    if (r_func == FUNC_SEARCH) begin
                        n_id = r_b; n_state = S_DONE;
                    end else if (r_s + CNT_W'(1) < r_fill) begin
                        n_state = S_RM_RD;
                    end else begin
                        meta_we = 1'b1; meta_wd = '{ld: r_ld, fill: r_fill - CNT_W'(1)};
                        n_state = S_DONE;
                    end
                end else if (r_s + CNT_W'(1) < r_fill) begin
                    n_s = r_s + CNT_W'(1); n_state = S_SRD;
                end else begin
                    n_status = ST_NOTFOUND; n_state = S_DONE;
                end
            end
            S_RM_RD: begin
                key_ra = {r_b, SLOT_W'(r_s + CNT_W'(1))};
                n_state = S_RM_WR;
            end
            S_RM_WR: begin
                key_we = 1'b1; key_wa = {r_b, r_s[SLOT_W-1:0]}; key_wd = key_q;
                n_s = r_s + CNT_W'(1);
                if (r_s + CNT_W'(2) < r_fill) n_state = S_RM_RD;
                else begin
                    meta_we = 1'b1; meta_wd = '{ld: r_ld, fill: r_fill - CNT_W'(1)};
                    n_state = S_DONE;
                end
            end
            S_DBL_RD: begin
                dir_ra = r_i; n_state = S_DBL_WR;
            end
            S_DBL_WR: begin
                dir_we = 1'b1; dir_wa = r_i + dir_n; dir_wd = dir_q;
                if (r_i == gd_mask) begin
                    n_gd = r_gd + DEP_W'(1); n_state = S_SPL;
                end else begin
                    n_i = r_i + DIR_W'(1); n_state = S_DBL_RD;
                end
            end
            S_SPL: begin
                if (r_used >= USED_W'(DIR_ENTRIES)) begin
                    n_status = ST_FULL; n_state = S_DONE;
                end else begin
                    n_nb = r_used[DIR_W-1:0]; n_used = r_used + USED_W'(1);
                    n_i = '0; n_state = S_WLK_RD;
                end
            end
            S_WLK_RD: begin
                dir_ra = r_i; n_state = S_WLK_WR;
            end
            S_WLK_WR: begin
                if (dir_q == r_b && r_i[r_ld[DEP_W-1:0]]) begin
                    dir_we = 1'b1; dir_wa = r_i; dir_wd = r_nb;
                end
                n_i = r_i + DIR_W'(1);
                if (r_i == dir_last) begin
                    n_s = '0; n_keep = '0; n_cnt = '0;
                    n_state = (r_fill == '0) ? S_M1 : S_RD_RD;
                end else n_state = S_WLK_RD;
            end
            S_RD_RD: n_state = S_RD_WR;
            S_RD_WR: begin
                key_we = 1'b1; key_wd = key_q;
                if (key_q[r_ld]) begin
                    key_wa = {r_nb, r_cnt[SLOT_W-1:0]}; n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    key_wa = {r_b, r_keep[SLOT_W-1:0]}; n_keep = r_keep + CNT_W'(1);
                end
                n_s = r_s + CNT_W'(1);
                n_state = (r_s + CNT_W'(1) == r_fill) ? S_M1 : S_RD_RD;
            end
            S_M1: begin
                meta_we = 1'b1; meta_wa = r_b;
                meta_wd = '{ld: r_ld + DEP_W'(1), fill: r_keep};
                n_state = S_M2;
            end
            S_M2: begin
                meta_we = 1'b1; meta_wa = r_nb;
                meta_wd = '{ld: r_ld + DEP_W'(1), fill: r_cnt};
                n_state = S_DIR;
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1; n_ostat = r_status; n_oid = r_id;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
        if (i_cfg_we && (i_cfg_index == CFG_INIT_DEPTH || i_cfg_index == CFG_CAPACITY)) begin
            n_state = S_CLR; n_i = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_i <= '0; r_ovalid <= 1'b0;
            r_init_depth <= 4'd0; r_cap_reg <= 4'd4;
            r_gd <= '0; r_used <= USED_W'(1);
        end else begin
            r_state <= n_state; r_i <= n_i; r_ovalid <= n_ovalid;
            r_gd <= n_gd; r_used <= n_used;
            if (i_cfg_we && i_cfg_index == CFG_INIT_DEPTH) r_init_depth <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_CAPACITY) r_cap_reg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func; r_key <= n_key; r_b <= n_b; r_nb <= n_nb; r_ld <= n_ld;
        r_fill <= n_fill; r_s <= n_s; r_keep <= n_keep; r_cnt <= n_cnt;
        r_status <= n_status; r_id <= n_id; r_ostat <= n_ostat; r_oid <= n_oid;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_status    = r_ostat;
    assign o_bucket_id = r_oid;

`ifndef SYNTHESIS
    a_clr_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> o_stall) else $error("input taken during clearing");
    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(DIR_ENTRIES)) else $error("bucket count overflow");
    a_gd_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gd <= DEP_W'(MAX_DEPTH)) else $error("global depth past limit");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_ovalid || !i_stall) && !i_cfg_we) |=> o_valid)
        else $error("finished item not presented");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_extendible_hash_table.sv =====
// Self-checking testbench for the extendible hash table: random and directed key operations.
`timescale 1ns / 1ps
module tb_extendible_hash_table;
    import eht_pkg::*;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] key;
    } t_op;

    typedef struct {
        logic [1:0] status;
        logic [9:0] bucket;
    } t_answer;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  in_func = '0;
    logic [31:0] in_key = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  out_status;
    logic [9:0]  out_bucket;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;

    extendible_hash_table u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_func(in_func), .i_key(in_key),
        .o_valid(out_valid), .i_stall(out_stall), .o_status(out_status),
        .o_bucket_id(out_bucket),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // table model
    int unsigned ht_init_depth;
    int unsigned ht_cap_reg;
    int unsigned ht_gdepth;
    int unsigned ht_dir[DIR_ENTRIES];
    int unsigned ht_ldepth[DIR_ENTRIES];
    int unsigned ht_fill[DIR_ENTRIES];
    logic [31:0] ht_keys[DIR_ENTRIES][SLOTS];
    int unsigned ht_used;

    t_op     pending_ops[$];
    t_answer expected_answers[$];
    int      errors = 0;
    bit      quiet_mode = 1'b0;   // no idling at end of run
    int      hold_left = 0;       // cycles left of the long receiver hold-off
    bit      in_taken = 1'b0;     // item accepted at the last rising edge
    int      live_keys[$];        // keys inserted recently, reused for hits

    function automatic void ht_clear();
        int unsigned d;
        d = (ht_init_depth > MAX_DEPTH) ? MAX_DEPTH : ht_init_depth;
        for (int i = 0; i < DIR_ENTRIES; i++) begin
            ht_dir[i] = 0; ht_ldepth[i] = 0; ht_fill[i] = 0;
        end
        for (int i = 0; i < (1 << d); i++) begin
            ht_dir[i] = i; ht_ldepth[i] = d;
        end
        ht_gdepth = d;
        ht_used = 1 << d;
    endfunction

    function automatic int unsigned ht_capacity();
        if (ht_cap_reg == 0) return 1;
        if (ht_cap_reg > SLOTS) return SLOTS;
        return ht_cap_reg;
    endfunction

    function automatic int unsigned ht_bucket_of(logic [31:0] key);
        int unsigned idx;
        idx = key & ((32'd1 << ht_gdepth) - 1);
        return ht_dir[idx & (DIR_ENTRIES - 1)];
    endfunction

    function automatic int ht_find(int unsigned b, logic [31:0] key);
        for (int s = 0; s < ht_fill[b] && s < SLOTS; s++)
            if (ht_keys[b][s] == key) return s;
        return -1;
    endfunction

    function automatic bit ht_split(int unsigned b);
        int unsigned ld, nb, keep, dir_n;
        logic [31:0] k;
        ld = ht_ldepth[b];
        if (ld >= ht_gdepth) begin
            if (ht_gdepth >= MAX_DEPTH) return 1'b0;
            dir_n = 1 << ht_gdepth;
            for (int i = 0; i < dir_n; i++) ht_dir[i + dir_n] = ht_dir[i];
            ht_gdepth++;
        end
        if (ht_used >= DIR_ENTRIES) return 1'b0;
        nb = ht_used++;
        dir_n = 1 << ht_gdepth;
        for (int i = 0; i < dir_n; i++)
            if (ht_dir[i] == b && ((i >> ld) & 1)) ht_dir[i] = nb;
        ht_ldepth[b] = ld + 1;
        ht_ldepth[nb] = ld + 1;
        ht_fill[nb] = 0;
        keep = 0;
        for (int s = 0; s < ht_fill[b] && s < SLOTS; s++) begin
            k = ht_keys[b][s];
            if (k[ld]) ht_keys[nb][ht_fill[nb]++] = k;
            else ht_keys[b][keep++] = k;
        end
        ht_fill[b] = keep;
        return 1'b1;
    endfunction

    function automatic t_answer ht_apply(t_op op);
        t_answer a;
        int unsigned b;
        int s;
        a.status = ST_OK;
        a.bucket = '0;
        case (op.func)
            FUNC_INSERT: begin
                a.status = ST_FULL;
                for (int t = 0; t <= MAX_DEPTH + 1; t++) begin
                    b = ht_bucket_of(op.key);
                    if (ht_fill[b] < ht_capacity()) begin
                        ht_keys[b][ht_fill[b]++] = op.key;
                        a.status = ST_OK;
                        break;
                    end
                    if (!ht_split(b)) break;
                end
            end
            FUNC_SEARCH: begin
                b = ht_bucket_of(op.key);
                if (ht_find(b, op.key) >= 0) a.bucket = b;
                else a.status = ST_NOTFOUND;
            end
            FUNC_REMOVE: begin
                b = ht_bucket_of(op.key);
                s = ht_find(b, op.key);
                if (s >= 0) begin
                    for (int j = s; j + 1 < ht_fill[b] && j + 1 < SLOTS; j++)
                        ht_keys[b][j] = ht_keys[b][j + 1];
                    ht_fill[b]--;
                end else begin
                    a.status = ST_NOTFOUND;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // input acceptance, seen at the rising edge
    always @(posedge clk) begin
        in_taken = 1'b0;
        if (rst_n && in_valid && !in_stall) begin
            expected_answers.insert(expected_answers.size(), ht_apply('{in_func, in_key}));
            void'(pending_ops.pop_front());
            in_taken = 1'b1;
        end
    end

    // sender: falling-edge driver with random gaps
    int send_gap = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_taken) begin
                // hold the item
            end else if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 8) - 1;
                in_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                in_valid <= 1'b1;
                in_func <= pending_ops[0].func;
                in_key <= pending_ops[0].key;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    int stall_left = 0;
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk) begin
        t_answer e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = expected_answers.pop_front();
                if (out_status !== e.status)
                    report_mismatch($sformatf("status %0d, want %0d", out_status, e.status));
                if (out_bucket !== e.bucket)
                    report_mismatch($sformatf("bucket %0d, want %0d", out_bucket, e.bucket));
            end
        end
    end

    function automatic logic [31:0] pick_key(int mode);
        case (mode)
            0: return $urandom_range(0, 15);
            1: return live_keys.size() ? live_keys[$urandom_range(0, live_keys.size() - 1)]
                                       : $urandom();
            2: return {2'($urandom_range(0, 3)), 28'h0, 2'($urandom_range(0, 3))};
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_op(logic [1:0] func, logic [31:0] key);
        pending_ops.insert(pending_ops.size(), '{func, key});
        if (func == FUNC_INSERT) begin
            live_keys.insert(live_keys.size(), key);
            if (live_keys.size() > 40) void'(live_keys.pop_front());
        end
    endtask

    task automatic drain();
        while (pending_ops.size() || in_valid || expected_answers.size()) @(posedge clk);
        repeat (3000) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [3:0] val);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_INIT_DEPTH) ht_init_depth = val;
        else ht_cap_reg = val;
        ht_clear();
        live_keys.delete();
    endtask

    task automatic random_phase(int n);
        int m;
        for (int i = 0; i < n; i++) begin
            m = $urandom_range(0, 9);
            if (m < 5) queue_op(FUNC_INSERT, pick_key($urandom_range(0, 3)));
            else if (m < 7) queue_op(FUNC_SEARCH, pick_key($urandom_range(0, 3)));
            else if (m < 9) queue_op(FUNC_REMOVE, pick_key($urandom_range(0, 3)));
            else queue_op(FUNC_UNUSED, $urandom());
        end
    endtask

    initial begin
        ht_init_depth = 0;
        ht_cap_reg = 4;
        ht_clear();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, all operations, unused code, duplicates to depth limit
        queue_op(FUNC_SEARCH, 32'h0);
        queue_op(FUNC_REMOVE, 32'h7fff_ffff);
        queue_op(FUNC_INSERT, 32'h0);
        queue_op(FUNC_INSERT, 32'hffff_ffff);
        queue_op(FUNC_INSERT, 32'h8000_0000);
        queue_op(FUNC_INSERT, 32'h7fff_ffff);
        queue_op(FUNC_INSERT, 32'h5555_5555);
        queue_op(FUNC_INSERT, 32'haaaa_aaaa);
        queue_op(FUNC_SEARCH, 32'hffff_ffff);
        queue_op(FUNC_SEARCH, 32'h8000_0000);
        queue_op(FUNC_REMOVE, 32'h0);
        queue_op(FUNC_REMOVE, 32'h0);
        queue_op(FUNC_UNUSED, 32'h1234_5678);
        for (int i = 0; i < 6; i++) queue_op(FUNC_INSERT, 32'h0000_0040);
        queue_op(FUNC_SEARCH, 32'h0000_0040);
        drain();

        // long receiver hold-off with the sender still offering items
        hold_left = 600;
        random_phase(40);
        wait (hold_left == 0);
        random_phase(160);
        drain();

        write_cfg(CFG_CAPACITY, 4'd1);
        write_cfg(CFG_INIT_DEPTH, 4'd10);
        random_phase(150);
        drain();

        write_cfg(CFG_INIT_DEPTH, 4'd15);
        write_cfg(CFG_CAPACITY, 4'd0);
        random_phase(100);
        drain();

        write_cfg(CFG_INIT_DEPTH, 4'd0);
        write_cfg(CFG_CAPACITY, 4'd1);
        // duplicates until the depth limit
        for (int i = 0; i < 14; i++) queue_op(FUNC_INSERT, 32'h0000_0400);
        random_phase(200);
        drain();

        write_cfg(CFG_CAPACITY, 4'd8);
        write_cfg(CFG_INIT_DEPTH, 4'd3);
        random_phase(300);
        drain();

        write_cfg(CFG_CAPACITY, 4'd15);
        write_cfg(CFG_INIT_DEPTH, 4'd1);
        random_phase(250);
        quiet_mode = 1'b1;
        random_phase(200);
        drain();

        if (errors == 0) begin
            $display("extendible_hash_table regression: pass");
        end else begin
            $display("extendible_hash_table regression: fail");
        end
        $finish;
    end

    initial begin
        #200000000;
        $display("extendible_hash_table regression: fail");
        $finish;
    end
endmodule
